### hdl/assert_macros.svh
// assertion macros used by the checker file of the rate limiter
// no dependencies; take in by include before the first use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define PIFRL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pifrl assertion failed");

// clocked check that also holds during reset
`define PIFRL_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pifrl assertion failed during reset");

`endif

### hdl/pifrl_pkg.sv
// shared types and constants of the per-identifier frame rate limiter
// used by every module of the block except pifrl_ram; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pifrl_pkg;

  localparam int unsigned TRACK_SLOTS_DEF = 16;

  localparam int unsigned ID_W       = 29;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned INTV_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FLAGS_W    = 6;
  localparam int unsigned OVR_SLOTS  = 3;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 64;
  localparam int unsigned M_TUSER_W = 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME     = 2'd0,
    REQ_CLEAR_TS  = 2'd1,
    REQ_CLEAR_ALL = 2'd2
  } req_type_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GLOBAL_INTERVAL = 3'd0,
    REG_OVERRIDE_FLAGS  = 3'd1,
    REG_OVR0_ID         = 3'd2,
    REG_OVR0_INTERVAL   = 3'd3,
    REG_OVR1_ID         = 3'd4,
    REG_OVR1_INTERVAL   = 3'd5,
    REG_OVR2_ID         = 3'd6,
    REG_OVR2_INTERVAL   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    BK_LOOK,
    BK_EXEC
  } back_state_e;

  // classified request as it travels from the front to the back
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] now_us;
    logic [INTV_W-1:0] interval;
    logic              blocked;
  } work_item_t;

endpackage

`default_nettype wire

### hdl/pifrl_ram.sv
// generic single-write, single-read RAM with registered read data
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module pifrl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [AddrW-1:0]      wr_addr_i,
  input  wire logic [WIDTH-1:0]      wr_data_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AddrW-1:0]      rd_addr_i,
  output logic      [WIDTH-1:0]      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/pifrl_front.sv
// front end: configuration registers and override classification of requests
// depends on pifrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module pifrl_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pifrl_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [pifrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [pifrl_pkg::REQ_W-1:0]        in_req_i,
  input  wire logic [pifrl_pkg::ID_W-1:0]         in_id_i,
  input  wire logic [pifrl_pkg::TIME_W-1:0]       in_now_i,
  output logic                                    push_valid_o,
  input  wire logic                               push_ready_i,
  output pifrl_pkg::work_item_t                   push_item_o
);

  logic [pifrl_pkg::INTV_W-1:0]  global_intv_q;
  logic [pifrl_pkg::FLAGS_W-1:0] flags_q;
  logic [pifrl_pkg::ID_W-1:0]    ovr_id_q   [pifrl_pkg::OVR_SLOTS];
  logic [pifrl_pkg::INTV_W-1:0]  ovr_intv_q [pifrl_pkg::OVR_SLOTS];

  logic [pifrl_pkg::INTV_W-1:0]  interval;
  logic                          blocked;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_intv_q <= '0;
      flags_q       <= '0;
      ovr_id_q      <= '{default: '0};
      ovr_intv_q    <= '{default: '0};
    end else if (cfg_valid_i) begin
      unique case (pifrl_pkg::cfg_reg_e'(cfg_addr_i))
        pifrl_pkg::REG_GLOBAL_INTERVAL: global_intv_q <= cfg_data_i[pifrl_pkg::INTV_W-1:0];
        pifrl_pkg::REG_OVERRIDE_FLAGS:  flags_q       <= cfg_data_i[pifrl_pkg::FLAGS_W-1:0];
        pifrl_pkg::REG_OVR0_ID:         ovr_id_q[0]   <= cfg_data_i[pifrl_pkg::ID_W-1:0];
        pifrl_pkg::REG_OVR0_INTERVAL:   ovr_intv_q[0] <= cfg_data_i[pifrl_pkg::INTV_W-1:0];
        pifrl_pkg::REG_OVR1_ID:         ovr_id_q[1]   <= cfg_data_i[pifrl_pkg::ID_W-1:0];
        pifrl_pkg::REG_OVR1_INTERVAL:   ovr_intv_q[1] <= cfg_data_i[pifrl_pkg::INTV_W-1:0];
        pifrl_pkg::REG_OVR2_ID:         ovr_id_q[2]   <= cfg_data_i[pifrl_pkg::ID_W-1:0];
        pifrl_pkg::REG_OVR2_INTERVAL:   ovr_intv_q[2] <= cfg_data_i[pifrl_pkg::INTV_W-1:0];
      endcase
    end
  end

  // walk down so the lowest matching override slot wins
  always_comb begin
    interval = global_intv_q;
    blocked  = 1'b0;
    for (int s = pifrl_pkg::OVR_SLOTS - 1; s >= 0; s--) begin
      if (flags_q[s] && (ovr_id_q[s] == in_id_i)) begin
        interval = ovr_intv_q[s];
        blocked  = flags_q[pifrl_pkg::OVR_SLOTS + s];
      end
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;
  assign push_item_o  = '{req:      in_req_i,
                          frame_id: in_id_i,
                          now_us:   in_now_i,
                          interval: interval,
                          blocked:  blocked};

endmodule

`default_nettype wire

### hdl/pifrl_queue.sv
// short queue between the classifying front and the table back end
// depends on pifrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module pifrl_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  pifrl_pkg::work_item_t     push_item_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output pifrl_pkg::work_item_t     pop_item_o
);

  pifrl_pkg::work_item_t             entry_q [pifrl_pkg::QUEUE_DEPTH];
  logic [pifrl_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [pifrl_pkg::QCNT_W-1:0]      count_q;
  logic                              push_fire, pop_fire;

  assign push_ready_o = (count_q != pifrl_pkg::QCNT_W'(pifrl_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hdl/pifrl_back.sv
// back end: tracking table lookup, pass decision, table update and counters
// depends on pifrl_pkg and pifrl_ram
`timescale 1ns / 1ps
`default_nettype none

module pifrl_back #(
  parameter int unsigned TRACK_SLOTS = pifrl_pkg::TRACK_SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            pop_valid_i,
  output logic                                 pop_ready_o,
  input  pifrl_pkg::work_item_t                pop_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_passed_o,
  output logic                                 out_full_o,
  output logic [pifrl_pkg::CNT_W-1:0]          out_accepted_o,
  output logic [pifrl_pkg::CNT_W-1:0]          out_rejected_o
);

  localparam int unsigned IdxW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

  pifrl_pkg::back_state_e            state_q, state_d;
  pifrl_pkg::work_item_t             item_q;

  logic [TRACK_SLOTS-1:0]            slot_valid_q;
  logic [pifrl_pkg::ID_W-1:0]        slot_ident_q [TRACK_SLOTS];

  logic [TRACK_SLOTS-1:0]            match;
  logic                              hit_c, free_any_c;
  logic [IdxW-1:0]                   hit_idx_c, free_idx_c;
  logic                              hit_q, free_any_q;
  logic [IdxW-1:0]                   hit_idx_q, free_idx_q;

  logic [pifrl_pkg::CNT_W-1:0]       pass_total_q, pass_total_d;
  logic [pifrl_pkg::CNT_W-1:0]       drop_total_q, drop_total_d;

  logic                              out_valid_q;
  logic                              out_passed_q, out_full_q;
  logic [pifrl_pkg::CNT_W-1:0]       out_acc_q, out_rej_q;

  logic                              pop_fire, can_fire, exec_fire;
  logic                              pass_c, full_c, wr_en, claim, clear_tbl;
  logic [IdxW-1:0]                   wr_idx;
  logic [pifrl_pkg::TIME_W-1:0]      last_pass;
  logic [pifrl_pkg::TIME_W:0]        elapsed;
  logic                              time_ok;

  assign pop_ready_o = (state_q == pifrl_pkg::BK_LOOK);
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign can_fire    = !out_valid_q || out_ready_i;

  // associative match of the incoming identifier and lowest free entry
  always_comb begin
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      match[i] = slot_valid_q[i] && (slot_ident_q[i] == pop_item_i.frame_id);
    end
    for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_c = IdxW'(i);
      end
      if (!slot_valid_q[i]) begin
        free_idx_c = IdxW'(i);
      end
    end
  end

  assign hit_c      = |match;
  assign free_any_c = !(&slot_valid_q);

  pifrl_ram #(
    .WIDTH (pifrl_pkg::TIME_W),
    .DEPTH (TRACK_SLOTS)
  ) u_last_pass (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx),
    .wr_data_i (item_q.now_us),
    .rd_en_i   (pop_fire),
    .rd_addr_i (hit_idx_c),
    .rd_data_o (last_pass)
  );

  // a borrow means time ran backwards, which counts as zero elapsed
  assign elapsed = {1'b0, item_q.now_us} - {1'b0, last_pass};
  assign time_ok = !elapsed[pifrl_pkg::TIME_W] &&
                   (elapsed[pifrl_pkg::TIME_W-1:0] >=
                    pifrl_pkg::TIME_W'(item_q.interval));

  always_comb begin
    state_d      = state_q;
    exec_fire    = 1'b0;
    pass_c       = 1'b0;
    full_c       = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = hit_idx_q;
    claim        = 1'b0;
    clear_tbl    = 1'b0;
    pass_total_d = pass_total_q;
    drop_total_d = drop_total_q;
    unique case (state_q)
      pifrl_pkg::BK_LOOK: begin
        if (pop_valid_i) begin
          state_d = pifrl_pkg::BK_EXEC;
        end
      end
      pifrl_pkg::BK_EXEC: begin
        if (can_fire) begin
          exec_fire = 1'b1;
          state_d   = pifrl_pkg::BK_LOOK;
          unique case (item_q.req)
            pifrl_pkg::REQ_FRAME: begin
              priority if (item_q.blocked) begin
                pass_c = 1'b0;
              end else if (item_q.interval == '0) begin
                pass_c = 1'b1;
              end else if (!hit_q) begin
                pass_c = 1'b1;
              end else begin
                pass_c = time_ok;
              end
              if (pass_c) begin
                if (hit_q) begin
                  wr_en = 1'b1;
                end else if (free_any_q) begin
                  wr_en  = 1'b1;
                  wr_idx = free_idx_q;
                  claim  = 1'b1;
                end else begin
                  full_c = 1'b1;
                end
                if (pass_total_q != pifrl_pkg::CNT_MAX) begin
                  pass_total_d = pass_total_q + pifrl_pkg::CNT_W'(1);
                end
              end else if (drop_total_q != pifrl_pkg::CNT_MAX) begin
                drop_total_d = drop_total_q + pifrl_pkg::CNT_W'(1);
              end
            end
            pifrl_pkg::REQ_CLEAR_TS: begin
              clear_tbl = 1'b1;
            end
            pifrl_pkg::REQ_CLEAR_ALL: begin
              clear_tbl    = 1'b1;
              pass_total_d = '0;
              drop_total_d = '0;
            end
            default: begin
              // unused request code answers like a clear and changes nothing
            end
          endcase
        end
      end
      default: begin
        state_d = pifrl_pkg::BK_LOOK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pifrl_pkg::BK_LOOK;
      slot_valid_q <= '0;
      pass_total_q <= '0;
      drop_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_total_q <= pass_total_d;
      drop_total_q <= drop_total_d;
      if (clear_tbl) begin
        slot_valid_q <= '0;
      end else if (claim) begin
        slot_valid_q[free_idx_q] <= 1'b1;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      item_q     <= pop_item_i;
      hit_q      <= hit_c;
      hit_idx_q  <= hit_idx_c;
      free_any_q <= free_any_c;
      free_idx_q <= free_idx_c;
    end
    if (claim) begin
      slot_ident_q[free_idx_q] <= item_q.frame_id;
    end
    if (exec_fire) begin
      out_passed_q <= pass_c;
      out_full_q   <= full_c;
      out_acc_q    <= pass_total_d;
      out_rej_q    <= drop_total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_passed_o   = out_passed_q;
  assign out_full_o     = out_full_q;
  assign out_accepted_o = out_acc_q;
  assign out_rejected_o = out_rej_q;

endmodule

`default_nettype wire

### hdl/per_id_frame_rate_limiter_unit.sv
// Per-identifier frame rate limiter. Each request (frame check or clear) gives one result.
// The front end takes one request per cycle into a two-entry queue while the queue has room
// and resolves the override slots on the way in; the back end handles every request in a
// look state, which searches the tracking table and reads the last pass time from its RAM,
// then an exec state, which compares elapsed time, updates the table and counters and loads
// the output register and waits there while the output is stalled. The back end takes no new
// request until it has finished the current one. Tracking entries carry valid bits cleared
// by reset and by clear requests, so no clearing pass runs after reset. Configuration writes
// take effect in the cycle after the transfer and are always accepted.
// depends on pifrl_pkg, pifrl_front, pifrl_queue, pifrl_back, pifrl_ram
`timescale 1ns / 1ps
`default_nettype none

module per_id_frame_rate_limiter_unit #(
  parameter int unsigned TRACK_SLOTS = pifrl_pkg::TRACK_SLOTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pifrl_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [pifrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // frame_id [28:0], now_us [92:29], zero pad [95:93]
  input  wire logic [pifrl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // req_type [1:0]
  input  wire logic [pifrl_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // accepted_count [31:0], rejected_count [63:32]
  output logic [pifrl_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // passed [0], tracking_full [1]
  output logic [pifrl_pkg::M_TUSER_W-1:0]         m_axis_tuser
);

  logic                              push_valid, push_ready;
  pifrl_pkg::work_item_t             push_item;
  logic                              pop_valid, pop_ready;
  pifrl_pkg::work_item_t             pop_item;
  logic                              out_passed, out_full;
  logic [pifrl_pkg::CNT_W-1:0]       out_acc, out_rej;

  pifrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_i     (s_axis_tuser),
    .in_id_i      (s_axis_tdata[pifrl_pkg::ID_W-1:0]),
    .in_now_i     (s_axis_tdata[pifrl_pkg::ID_W+pifrl_pkg::TIME_W-1:pifrl_pkg::ID_W]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  pifrl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  pifrl_back #(
    .TRACK_SLOTS (TRACK_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_passed_o   (out_passed),
    .out_full_o     (out_full),
    .out_accepted_o (out_acc),
    .out_rejected_o (out_rej)
  );

  assign m_axis_tdata = {out_rej, out_acc};
  assign m_axis_tuser = {out_full, out_passed};

endmodule

`default_nettype wire

### hdl/pifrl_checker.sv
// port-level checks of the rate limiter, bound to the top level
// depends on pifrl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pifrl_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic                               cfg_ready_o,
  input  wire logic [pifrl_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [pifrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  input  wire logic                               s_axis_tready,
  input  wire logic [pifrl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic [pifrl_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  input  wire logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic [pifrl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  wire logic [pifrl_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

  // a stalled result keeps its transfer contents
  `PIFRL_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // no result is offered while reset is held
  `PIFRL_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

  // an unrecorded frame still passed, so the pass count is at least one
  `PIFRL_ASSERT(a_full_means_pass, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && (m_axis_tdata[31:0] != 32'd0))

endmodule

bind per_id_frame_rate_limiter_unit pifrl_checker u_checker (.*);

`default_nettype wire
